FILE: rtl/gner_pkg.sv
// ----------------------------------------------------------------------------
// gner_pkg: shared types and constants for the greedy route unit
// Payload structs, controller state, command and status groups.
// ----------------------------------------------------------------------------
package gner_pkg;

    localparam int NODES_DEF = 8;
    localparam int NODE_W    = 3;
    localparam int WEIGHT_W  = 16;
    localparam int TOTAL_W   = 19;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic STAT_ROUTE    = 1'b0;
    localparam logic STAT_NO_ROUTE = 1'b1;

    typedef struct packed {
        logic                action;
        logic [NODE_W-1:0]   from_node;
        logic [NODE_W-1:0]   to_node;
        logic [WEIGHT_W-1:0] weight;
        logic [NODE_W-1:0]   start_node;
        logic [NODE_W-1:0]   end_node;
    } t_in_item;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_time;
        logic               status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_EVAL,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        RSEL_TRIVIAL,
        RSEL_NO_ROUTE,
        RSEL_ROUTE
    } t_res_sel;

    typedef struct packed {
        logic     clr_we;
        logic     wr_en;
        logic     load_query;
        logic     scan_issue;
        logic     eval;
        logic     res_set;
        t_res_sel res_sel;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
        logic trivial;
        logic out_of_range;
        logic clr_last;
        logic col_last;
        logic found;
        logic next_is_end;
        logic steps_max;
        logic out_free;
    } t_dp_status;

endpackage

FILE: rtl/gner_ctrl.sv
// ----------------------------------------------------------------------------
// gner_ctrl: sequencer for the greedy route unit
// Runs the clearing pass, takes transfers, steps row scans and result hand-off.
// ----------------------------------------------------------------------------
module gner_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  gner_pkg::t_dp_status  i_status,
    output gner_pkg::t_dp_cmd     o_cmd,
    output logic                  o_in_stall
);
    import gner_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid && i_status.is_query) begin
                    if (i_status.trivial || i_status.out_of_range) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_status.col_last) n_state = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!i_status.found || i_status.next_is_end || i_status.steps_max) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_OUT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (!i_status.is_query) begin
                        o_cmd.wr_en = 1'b1;
                    end else if (i_status.trivial) begin
                        o_cmd.res_set = 1'b1;
                        o_cmd.res_sel = RSEL_TRIVIAL;
                    end else if (i_status.out_of_range) begin
                        o_cmd.res_set = 1'b1;
                        o_cmd.res_sel = RSEL_NO_ROUTE;
                    end else begin
                        o_cmd.load_query = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
            end
            S_WAIT: begin
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (!i_status.found) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = RSEL_NO_ROUTE;
                end else if (i_status.next_is_end) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = RSEL_ROUTE;
                end else if (i_status.steps_max) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = RSEL_NO_ROUTE;
                end
            end
            S_OUT: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/gner_dp.sv
// ----------------------------------------------------------------------------
// gner_dp: datapath for the greedy route unit
// Edge memory, row scan with running minimum, route total and result register.
// ----------------------------------------------------------------------------
module gner_dp #(
    parameter int NODES = gner_pkg::NODES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gner_pkg::t_in_item   i_in_item,
    input  gner_pkg::t_dp_cmd    i_cmd,
    input  logic                 i_out_stall,
    output gner_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    output gner_pkg::t_out_item  o_out_item
);
    import gner_pkg::*;

    localparam int DEPTH = NODES * NODES;
    localparam int NW    = $clog2(NODES);
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = NODE_W + 4;   // compare width, holds NODES up to 64

    logic [WEIGHT_W-1:0] mem [DEPTH];

    logic [AW-1:0]       r_clr;
    logic [NW-1:0]       r_node;
    logic [NW-1:0]       r_end;
    logic [NW-1:0]       r_col;
    logic [NW-1:0]       r_rd_col;
    logic                r_rd_vld;
    logic [WEIGHT_W-1:0] r_rd_data;
    logic [WEIGHT_W-1:0] r_best;
    logic [NW-1:0]       r_next;
    logic                r_found;
    logic [NW-1:0]       r_steps;
    logic [TOTAL_W-1:0]  r_total;
    t_out_item           r_res;
    t_out_item           r_out;
    logic                r_out_valid;

    logic                wr_ok;
    logic                we;
    logic [AW-1:0]       wr_addr;
    logic [WEIGHT_W-1:0] wr_data;
    logic [AW-1:0]       rd_addr;
    logic [TOTAL_W:0]    sum;
    logic [TOTAL_W-1:0]  sum_sat;
    logic                take;

    // index checks on the raw 3-bit fields
    assign wr_ok = (CW'(i_in_item.from_node) < CW'(NODES)) &&
                   (CW'(i_in_item.to_node) < CW'(NODES));

    assign we      = i_cmd.clr_we || (i_cmd.wr_en && wr_ok);
    assign wr_addr = i_cmd.clr_we ? r_clr :
                     AW'(AW'(NW'(i_in_item.from_node)) * AW'(NODES) +
                         AW'(NW'(i_in_item.to_node)));
    assign wr_data = i_cmd.clr_we ? '0 : i_in_item.weight;
    assign rd_addr = AW'(AW'(r_node) * AW'(NODES) + AW'(r_col));

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.scan_issue) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign sum     = {1'b0, r_total} + (TOTAL_W + 1)'(r_best);
    assign sum_sat = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    assign take    = r_rd_vld && (r_rd_data != '0) && (!r_found || r_rd_data < r_best);

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_col       <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_we) r_clr <= r_clr + AW'(1);
            r_rd_vld <= i_cmd.scan_issue;
            if (i_cmd.load_query || i_cmd.eval) begin
                r_col   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.scan_issue) r_col <= r_col + NW'(1);
                if (take) r_found <= 1'b1;
            end
            if (i_cmd.load_query) begin
                r_steps <= '0;
            end else if (i_cmd.eval) begin
                r_steps <= r_steps + NW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_node  <= NW'(i_in_item.start_node);
            r_end   <= NW'(i_in_item.end_node);
            r_total <= '0;
        end else if (i_cmd.eval) begin
            r_node  <= r_next;
            r_total <= sum_sat;
        end
        if (take) begin
            r_best <= r_rd_data;
            r_next <= r_rd_col;
        end
        if (i_cmd.scan_issue) r_rd_col <= r_col;
        if (i_cmd.res_set) begin
            case (i_cmd.res_sel)
                RSEL_TRIVIAL: begin
                    r_res.total_time <= '0;
                    r_res.status     <= STAT_ROUTE;
                end
                RSEL_ROUTE: begin
                    r_res.total_time <= sum_sat;
                    r_res.status     <= STAT_ROUTE;
                end
                default: begin
                    r_res.total_time <= '0;
                    r_res.status     <= STAT_NO_ROUTE;
                end
            endcase
        end
        if (i_cmd.out_load) r_out <= r_res;
    end

    assign o_status.is_query     = (i_in_item.action == ACT_QUERY);
    assign o_status.trivial      = (i_in_item.start_node == i_in_item.end_node);
    assign o_status.out_of_range = (CW'(i_in_item.start_node) >= CW'(NODES)) ||
                                   (CW'(i_in_item.end_node) >= CW'(NODES));
    assign o_status.clr_last     = (r_clr == AW'(DEPTH - 1));
    assign o_status.col_last     = (r_col == NW'(NODES - 1));
    assign o_status.found        = r_found;
    assign o_status.next_is_end  = (r_next == r_end);
    assign o_status.steps_max    = (r_steps == NW'(NODES - 1));
    assign o_status.out_free     = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: rtl/greedy_nearest_edge_route_unit.sv
// ----------------------------------------------------------------------------
// greedy_nearest_edge_route_unit: greedy nearest-edge route finder
// Directed weighted edge table with write and route-query transfers.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  in      | input     | i_in_valid/o_in_stall | i_in_item  (t_in_item)
//  out     | output    | o_out_valid/i_out_stall | o_out_item (t_out_item)
//
//  An edge write is taken while idle. A query with start equal to end, or
//  with a node index out of range, goes via the result register to the
//  output register with no row scan. A walking query takes up to NODES hops,
//  each scanning one memory row through the single read port, one row entry
//  a cycle. After reset a clearing pass zeroes all NODES*NODES entries, with
//  the input stalled. A full output register holds the unit in its result
//  state until it is taken; the input stalls during any query.
//
module greedy_nearest_edge_route_unit #(
    parameter int NODES = gner_pkg::NODES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gner_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output gner_pkg::t_out_item o_out_item
);
    import gner_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencer: clearing pass, transfer decode, scan stepping
    gner_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // datapath: edge memory, running minimum, saturating total, result reg
    gner_dp #(
        .NODES (NODES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
